// ----- rtl/core/lss_pkg.sv -----
// Shared types and codes for the byte-wide LIFO stack with search.
`timescale 1ns / 1ps

package lss_pkg;

	localparam int unsigned DATA_W = 8;
	localparam int unsigned POS_W  = 6;
	localparam int unsigned FILL_W = 7;

	typedef enum logic [2:0] {
		KIND_PUSH    = 3'd0,
		KIND_POP     = 3'd1,
		KIND_PEEK    = 3'd2,
		KIND_REPLACE = 3'd3,
		KIND_CLEAR   = 3'd4,
		KIND_SEARCH  = 3'd5,
		KIND_MEDIAN  = 3'd6,
		KIND_STATUS  = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_EMPTY = 2'd1,
		ERR_FULL  = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		kind_t               kind;
		logic [DATA_W-1:0]   value;
	} cmd_t;

	typedef struct packed {
		logic [DATA_W-1:0]   item;
		logic [POS_W-1:0]    position;
		logic                found;
		logic [FILL_W-1:0]   fill_count;
		logic                empty_flag;
		logic                full_flag;
		err_t                error_code;
	} rsp_t;

endpackage

// ----- rtl/core/lss_mem.sv -----
// Stack storage: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module lss_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [lss_pkg::DATA_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic [lss_pkg::DATA_W-1:0] rdata
);
	import lss_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/lss_ctrl.sv -----
// Command sequencer: fill level, memory access, search scan and result build.
`timescale 1ns / 1ps

module lss_ctrl #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6,
	parameter int unsigned CW    = 7
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_ready,
	input  lss_pkg::cmd_t              cmd,
	output logic                       res_valid,
	input  logic                       res_ready,
	output lss_pkg::rsp_t              res,
	output logic                       mem_we,
	output logic [AW-1:0]              mem_waddr,
	output logic [lss_pkg::DATA_W-1:0] mem_wdata,
	output logic [AW-1:0]              mem_raddr,
	input  logic [lss_pkg::DATA_W-1:0] mem_rdata
);
	import lss_pkg::*;

	state_t            state_q, state_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [AW-1:0]     idx_q;
	logic [DATA_W-1:0] key_q;
	rsp_t              res_q, res_d;

	logic              accept;
	logic              is_empty;
	logic              is_full;
	logic [CW-1:0]     cnt_m1;
	logic [CW-1:0]     cnt_half;
	logic              match;
	logic              scan_last;
	err_t              err;

	assign is_empty  = (cnt_q == '0);
	assign is_full   = (cnt_q == CW'(DEPTH));
	assign cnt_m1    = cnt_q - CW'(1);
	assign cnt_half  = cnt_q >> 1;
	assign match     = (mem_rdata == key_q);
	assign scan_last = (idx_q == '0);

	assign cmd_ready = (state_q == ST_IDLE) || ((state_q == ST_DONE) && res_ready);
	assign accept    = cmd_valid && cmd_ready;
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		err       = ERR_NONE;
		mem_we    = 1'b0;
		mem_waddr = cnt_q[AW-1:0];
		mem_wdata = cmd.value;
		mem_raddr = cnt_m1[AW-1:0];

		unique case (state_q)
			ST_IDLE, ST_DONE: begin
				if (state_q == ST_DONE && res_ready) begin
					state_d = ST_IDLE;
				end
				if (accept) begin
					state_d = ST_DONE;
					unique case (cmd.kind)
						KIND_PUSH: begin
							if (is_full) begin
								err = ERR_FULL;
							end else begin
								mem_we = 1'b1;
								cnt_d  = cnt_q + CW'(1);
							end
						end
						KIND_POP: begin
							if (is_empty) begin
								err = ERR_EMPTY;
							end else begin
								cnt_d   = cnt_m1;
								state_d = ST_READ;
							end
						end
						KIND_PEEK: begin
							if (is_empty) begin
								err = ERR_EMPTY;
							end else begin
								state_d = ST_READ;
							end
						end
						KIND_REPLACE: begin
							mem_we = 1'b1;
							if (is_empty) begin
								err       = ERR_EMPTY;
								mem_waddr = '0;
								cnt_d     = CW'(1);
							end else begin
								mem_waddr = cnt_m1[AW-1:0];
							end
						end
						KIND_CLEAR: begin
							cnt_d = '0;
						end
						KIND_SEARCH: begin
							if (!is_empty) begin
								state_d = ST_SCAN;
							end
						end
						KIND_MEDIAN: begin
							mem_raddr = cnt_half[AW-1:0];
							if (is_empty) begin
								err = ERR_EMPTY;
							end else begin
								state_d = ST_READ;
							end
						end
						KIND_STATUS: begin
						end
						default: begin
						end
					endcase
				end
			end
			ST_READ: begin
				state_d = ST_DONE;
			end
			ST_SCAN: begin
				// The entry at idx_q is on the read port now; fetch the one below it.
				mem_raddr = idx_q - AW'(1);
				if (match || scan_last) begin
					state_d = ST_DONE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		res_d            = '0;
		res_d.fill_count = FILL_W'(cnt_d);
		res_d.empty_flag = (cnt_d == '0);
		res_d.full_flag  = (cnt_d == CW'(DEPTH));
		res_d.error_code = err;
	end

	// Writes happen only at the edge that takes a command and reads are
	// issued at that edge or later, so a read never meets a pending write.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
			idx_q <= cnt_m1[AW-1:0];
			key_q <= cmd.value;
		end else if (state_q == ST_READ) begin
			res_q.item <= mem_rdata;
		end else if (state_q == ST_SCAN) begin
			idx_q <= idx_q - AW'(1);
			if (match) begin
				res_q.found    <= 1'b1;
				res_q.position <= POS_W'(idx_q);
			end
		end
	end

endmodule

// ----- rtl/core/lifo_stack_with_search.sv -----
// Top level of the byte-wide LIFO stack with search and its output register.
//
//   Channel  Handshake              Payload  Direction
//   cmd      cmd_valid / cmd_ready  cmd_t    in
//   rsp      rsp_valid / rsp_ready  rsp_t    out
//
// Push, replace, clear, status, any rejected command and a search of an empty stack
// go straight to the result state; while results are taken they can follow back to back.
// Pop, peek and median pass through ST_READ for the registered memory read.
// Search scans the entries from the top down through the single read port, one
// entry a cycle, stopping at the first match or after the bottom entry.
// Reset empties the stack at once; the storage itself is never cleared.
// A stalled result waits in the output register while the next item is taken.
`timescale 1ns / 1ps

module lifo_stack_with_search #(
	parameter int unsigned DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  lss_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output lss_pkg::rsp_t rsp
);
	import lss_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic              res_valid;
	logic              res_ready;
	rsp_t              res;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic [AW-1:0]     mem_raddr;
	logic [DATA_W-1:0] mem_rdata;

	logic              out_valid_q;
	rsp_t              out_q;

	lss_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	lss_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign res_ready = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

`ifndef ASSERT_OFF
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.empty_flag && rsp.full_flag))
		else $error("empty and full reported together");

	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.error_code == ERR_FULL) |-> rsp.full_flag)
		else $error("push rejected while the stack was not full");

	a_found_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.found) |-> (rsp.error_code == ERR_NONE && !rsp.empty_flag))
		else $error("search match reported with an error or an empty stack");

	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> res_valid)
		else $error("result dropped while the output register was occupied");
`endif

endmodule

// ----- verif/tb_lifo_stack_with_search.sv -----
// Self-checking LIFO-with-search testbench: directed table, fill to full depth, then random runs.
`timescale 1ns / 1ps

module tb_lifo_stack_with_search;

	import lss_pkg::*;

	localparam int DEPTH        = 64;
	localparam int RANDOM_ITEMS = 1600;
	localparam int QUIET_LIMIT  = 2000;
	localparam int SETTLE_CYCLES = 80;

	typedef struct {
		kind_t             kind;
		logic [DATA_W-1:0] value;
		bit                typed;
		rsp_t              want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	// Shadow copy of the stack contents and fill level.
	logic [DATA_W-1:0] shadow_mem [DEPTH];
	int                shadow_level;

	rsp_t     pending_rsp [$];
	dir_row_t dir_rows [$];
	int       accepted_count;
	int       mismatch_count;
	int       quiet_cycles;
	bit       idle_on;

	lifo_stack_with_search #(
		.DEPTH(DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic rsp_t typed_rsp(logic [DATA_W-1:0] item, int pos, bit found, int fill,
			err_t err);
		rsp_t r;
		r.item       = item;
		r.position   = POS_W'(pos);
		r.found      = found;
		r.fill_count = FILL_W'(fill);
		r.empty_flag = (fill == 0);
		r.full_flag  = (fill == DEPTH);
		r.error_code = err;
		return r;
	endfunction

	// Works out the result of one command and updates the shadow stack.
	function automatic rsp_t stack_response(cmd_t c);
		rsp_t r;
		r = '0;
		r.error_code = ERR_NONE;
		case (c.kind)
			KIND_PUSH: begin
				if (shadow_level >= DEPTH) begin
					r.error_code = ERR_FULL;
				end else begin
					shadow_mem[shadow_level] = c.value;
					shadow_level++;
				end
			end
			KIND_POP: begin
				if (shadow_level == 0) begin
					r.error_code = ERR_EMPTY;
				end else begin
					shadow_level--;
					r.item = shadow_mem[shadow_level];
				end
			end
			KIND_PEEK: begin
				if (shadow_level == 0)
					r.error_code = ERR_EMPTY;
				else
					r.item = shadow_mem[shadow_level - 1];
			end
			KIND_REPLACE: begin
				if (shadow_level == 0) begin
					shadow_mem[0] = c.value;
					shadow_level = 1;
					r.error_code = ERR_EMPTY;
				end else begin
					shadow_mem[shadow_level - 1] = c.value;
				end
			end
			KIND_CLEAR: shadow_level = 0;
			KIND_SEARCH: begin
				// The match nearest the top wins, so scan downwards and keep the first hit.
				for (int k = shadow_level - 1; k >= 0; k--) begin
					if (!r.found && shadow_mem[k] == c.value) begin
						r.found    = 1'b1;
						r.position = POS_W'(k);
					end
				end
			end
			KIND_MEDIAN: begin
				if (shadow_level == 0)
					r.error_code = ERR_EMPTY;
				else
					r.item = shadow_mem[shadow_level / 2];
			end
			default: ;
		endcase
		r.fill_count = FILL_W'(shadow_level);
		r.empty_flag = (shadow_level == 0);
		r.full_flag  = (shadow_level == DEPTH);
		return r;
	endfunction

	// When the stack is not empty, half the time a value already on it, so that searches hit.
	function automatic logic [DATA_W-1:0] pick_value();
		if (shadow_level > 0 && $urandom_range(0, 1) == 0)
			return shadow_mem[$urandom_range(0, shadow_level - 1)];
		return DATA_W'($urandom_range(0, 255));
	endfunction

	task automatic add_row(kind_t k, logic [DATA_W-1:0] v, bit typed, rsp_t want);
		dir_row_t row;
		row.kind  = k;
		row.value = v;
		row.typed = typed;
		row.want  = want;
		dir_rows.push_back(row);
	endtask

	// Presents one item and holds it until accepted; the expectation is queued at acceptance.
	task automatic send_cmd(kind_t k, logic [DATA_W-1:0] v, bit typed, rsp_t want);
		cmd_t nxt;
		rsp_t predicted;
		int   gap;
		nxt.kind  = k;
		nxt.value = v;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 14);
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= nxt;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		predicted = stack_response(nxt);
		pending_rsp.push_back(typed ? want : predicted);
		accepted_count++;
	endtask

	task automatic send_random(kind_t k);
		send_cmd(k, pick_value(), 1'b0, '0);
	endtask

	task automatic report_rsp(string what, rsp_t want, rsp_t got, bit have_want);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t: %s", $realtime, what);
			if (have_want)
				$display("  expected item=%02h pos=%0d found=%0b fill=%0d empty=%0b full=%0b err=%0d",
					want.item, want.position, want.found, want.fill_count, want.empty_flag,
					want.full_flag, want.error_code);
			$display("  actual   item=%02h pos=%0d found=%0b fill=%0d empty=%0b full=%0b err=%0d",
				got.item, got.position, got.found, got.fill_count, got.empty_flag,
				got.full_flag, got.error_code);
		end
	endtask

	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				report_rsp("result with no command outstanding", '0, rsp, 1'b0);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.item !== want.item || rsp.position !== want.position
						|| rsp.found !== want.found || rsp.fill_count !== want.fill_count
						|| rsp.empty_flag !== want.empty_flag || rsp.full_flag !== want.full_flag
						|| rsp.error_code !== want.error_code)
					report_rsp("result mismatch", want, rsp, 1'b1);
			end
		end
	end

	// Receiver side: ready is dropped now and then, at random, while idling is enabled.
	initial begin : rsp_side
		int stall;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 14);
				rsp_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int random_end;
		int burst;
		int r;
		cmd_valid      = 1'b0;
		cmd            = '0;
		arst_n         = 1'b0;
		shadow_level   = 0;
		accepted_count = 0;
		idle_on        = 1'b1;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_row(KIND_STATUS,  8'h00, 1'b1, typed_rsp(8'h00, 0, 1'b0, 0, ERR_NONE));
		add_row(KIND_POP,     8'h00, 1'b1, typed_rsp(8'h00, 0, 1'b0, 0, ERR_EMPTY));
		add_row(KIND_PEEK,    8'hFF, 1'b1, typed_rsp(8'h00, 0, 1'b0, 0, ERR_EMPTY));
		add_row(KIND_MEDIAN,  8'h00, 1'b1, typed_rsp(8'h00, 0, 1'b0, 0, ERR_EMPTY));
		add_row(KIND_SEARCH,  8'h00, 1'b1, typed_rsp(8'h00, 0, 1'b0, 0, ERR_NONE));
		add_row(KIND_REPLACE, 8'hFF, 1'b1, typed_rsp(8'h00, 0, 1'b0, 1, ERR_EMPTY));
		add_row(KIND_PUSH,    8'h00, 1'b1, typed_rsp(8'h00, 0, 1'b0, 2, ERR_NONE));
		add_row(KIND_PEEK,    8'h00, 1'b1, typed_rsp(8'h00, 0, 1'b0, 2, ERR_NONE));
		add_row(KIND_SEARCH,  8'hFF, 1'b1, typed_rsp(8'h00, 0, 1'b1, 2, ERR_NONE));
		add_row(KIND_MEDIAN,  8'h00, 1'b1, typed_rsp(8'h00, 0, 1'b0, 2, ERR_NONE));
		add_row(KIND_REPLACE, 8'hA5, 1'b0, '0);
		add_row(KIND_PUSH,    8'h5A, 1'b0, '0);
		add_row(KIND_PUSH,    8'hA5, 1'b0, '0);
		add_row(KIND_SEARCH,  8'hA5, 1'b0, '0);
		add_row(KIND_MEDIAN,  8'h00, 1'b0, '0);
		add_row(KIND_POP,     8'h00, 1'b0, '0);
		add_row(KIND_POP,     8'h00, 1'b0, '0);
		add_row(KIND_SEARCH,  8'h00, 1'b0, '0);
		add_row(KIND_CLEAR,   8'h00, 1'b1, typed_rsp(8'h00, 0, 1'b0, 0, ERR_NONE));
		add_row(KIND_PEEK,    8'h00, 1'b1, typed_rsp(8'h00, 0, 1'b0, 0, ERR_EMPTY));
		add_row(KIND_PUSH,    8'h80, 1'b1, typed_rsp(8'h00, 0, 1'b0, 1, ERR_NONE));
		add_row(KIND_SEARCH,  8'h80, 1'b1, typed_rsp(8'h00, 0, 1'b1, 1, ERR_NONE));
		add_row(KIND_POP,     8'h00, 1'b1, typed_rsp(8'h80, 0, 1'b0, 0, ERR_NONE));

		foreach (dir_rows[i])
			send_cmd(dir_rows[i].kind, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);

		// Fill to the top, then a rejected push and reads at full depth.
		for (int i = 0; i < DEPTH; i++)
			send_cmd(KIND_PUSH, DATA_W'(i * 4 + 3), 1'b0, '0);
		send_cmd(KIND_PUSH, 8'hFF, 1'b1, typed_rsp(8'h00, 0, 1'b0, DEPTH, ERR_FULL));
		send_cmd(KIND_SEARCH, 8'h03, 1'b1, typed_rsp(8'h00, 0, 1'b1, DEPTH, ERR_NONE));
		send_cmd(KIND_SEARCH, 8'h00, 1'b1, typed_rsp(8'h00, 0, 1'b0, DEPTH, ERR_NONE));
		send_cmd(KIND_MEDIAN, 8'h00, 1'b0, '0);
		send_cmd(KIND_PEEK, 8'h00, 1'b0, '0);

		random_end = accepted_count + RANDOM_ITEMS;
		while (accepted_count < random_end) begin
			if (accepted_count > random_end - 200)
				idle_on = 1'b0;
			r = $urandom_range(0, 9);
			if (r == 0) begin
				while (shadow_level < DEPTH) begin
					if ($urandom_range(0, 7) == 0)
						send_random(($urandom_range(0, 1) == 0) ? KIND_SEARCH : KIND_PEEK);
					else
						send_random(KIND_PUSH);
				end
				repeat ($urandom_range(1, 3))
					send_random(KIND_PUSH);
				send_random(KIND_SEARCH);
				send_random(KIND_MEDIAN);
			end else if (r == 1) begin
				while (shadow_level > 0) begin
					if ($urandom_range(0, 7) == 0)
						send_random(($urandom_range(0, 1) == 0) ? KIND_MEDIAN : KIND_SEARCH);
					else
						send_random(KIND_POP);
				end
				repeat ($urandom_range(1, 2))
					send_random(kind_t'($urandom_range(KIND_POP, KIND_PEEK)));
				send_random(KIND_MEDIAN);
			end else begin
				burst = $urandom_range(8, 30);
				repeat (burst) begin
					r = $urandom_range(0, 11);
					// Extra weight on push keeps the stack from sitting empty.
					if (r > 7)
						send_random(KIND_PUSH);
					else
						send_random(kind_t'(r));
				end
			end
		end

		@(negedge clk);
		cmd_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/lss_pkg.sv
rtl/core/lss_mem.sv
rtl/core/lss_ctrl.sv
rtl/core/lifo_stack_with_search.sv
verif/tb_lifo_stack_with_search.sv
